// ===== rtl/core/two_queues_shared_buffer_core_macros.svh =====
// Assertion shorthands shared by the core's modules.
// Every check is sampled on clk_i and is off while rst_ni is low.
`ifndef TWO_QUEUES_SHARED_BUFFER_CORE_MACROS_SVH
`define TWO_QUEUES_SHARED_BUFFER_CORE_MACROS_SVH

// A property that must hold at every rising edge of clk_i.
`define TQSB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define TQSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tqsb_pkg.sv =====
package tqsb_pkg;

  // Number of buffer slots shared by the two queues.
  localparam int SLOTS     = 16;
  localparam int ADDR_W    = $clog2(SLOTS);
  // Signed pointer width: holds -1 and SLOTS.
  localparam int PTR_W     = $clog2(SLOTS) + 2;
  localparam int DATA_W    = 32;
  localparam int REQ_W     = 3;
  localparam int SLOT_W    = 4;
  // A listing stops after this many results.
  localparam int LIST_MAX  = 16;
  localparam int CNT_W     = $clog2(LIST_MAX);

  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic signed [PTR_W-1:0]  ptr_t;
  typedef logic [SLOT_W-1:0]        slot_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_L = 3'd0,
    REQ_POP_L  = 3'd1,
    REQ_LIST_L = 3'd2,
    REQ_PUSH_R = 3'd3,
    REQ_POP_R  = 3'd4,
    REQ_LIST_R = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVF   = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // One result item handed from the controller to the output register.
  typedef struct packed {
    status_e status;
    slot_t   slot;
    data_t   data;
    logic    last;
  } res_t;

endpackage

// ===== rtl/core/two_queues_shared_buffer_core.sv =====
// Channel | Handshake                | Payload
// --------+--------------------------+------------------------------------------
// in      | in_valid_i / in_ready_o  | req_type_i, push_value_i
// out     | out_valid_o / out_ready_i| status_o, slot_o, data_out_o, last_o
//
// One request is worked on at a time. A push or a failed request is answered from
// S_EXEC; a pop or a listing issues a registered read of the buffer RAM there and
// is answered from S_READ, one buffer entry per result.
// A result register sits on the output, so a new request is taken while a result waits.
// rst_ni clears the queue pointers and control state; the buffer RAM is not cleared.
// A stalled output holds the controller in place; nothing is dropped or repeated.
module two_queues_shared_buffer_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [tqsb_pkg::REQ_W-1:0]         req_type_i,
  input  logic signed [tqsb_pkg::DATA_W-1:0] push_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         status_o,
  output logic [tqsb_pkg::SLOT_W-1:0]        slot_o,
  output logic signed [tqsb_pkg::DATA_W-1:0] data_out_o,
  output logic                               last_o
);

  logic                          res_valid, res_ready;
  tqsb_pkg::res_t                res;
  logic                          ram_we, ram_re;
  tqsb_pkg::addr_t               ram_waddr, ram_raddr;
  logic [tqsb_pkg::DATA_W-1:0]   ram_wdata, ram_rdata;
  logic                          out_valid_q, out_valid_d;
  tqsb_pkg::res_t                out_q;

  tqsb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .push_value_i (push_value_i),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  tqsb_ram #(
    .WIDTH (tqsb_pkg::DATA_W),
    .DEPTH (tqsb_pkg::SLOTS)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The result register takes a new transaction whenever it is empty or drains now.
  assign res_ready   = !out_valid_q || out_ready_i;
  assign out_valid_d = res_valid || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign slot_o      = out_q.slot;
  assign data_out_o  = out_q.data;
  assign last_o      = out_q.last;

endmodule

// ===== rtl/core/tqsb_ram.sv =====
module tqsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tqsb_ctrl.sv =====
`include "two_queues_shared_buffer_core_macros.svh"

module tqsb_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tqsb_pkg::REQ_W-1:0]     req_type_i,
  input  tqsb_pkg::data_t                push_value_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output tqsb_pkg::res_t                 res_o,
  output logic                           ram_we_o,
  output tqsb_pkg::addr_t                ram_waddr_o,
  output logic [tqsb_pkg::DATA_W-1:0]    ram_wdata_o,
  output logic                           ram_re_o,
  output tqsb_pkg::addr_t                ram_raddr_o,
  input  logic [tqsb_pkg::DATA_W-1:0]    ram_rdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_e;

  state_e                       state_q, state_d;
  logic [tqsb_pkg::REQ_W-1:0]   req_q;
  tqsb_pkg::data_t              val_q;
  tqsb_pkg::ptr_t               left_front_q, left_front_d;
  tqsb_pkg::ptr_t               left_rear_q, left_rear_d;
  tqsb_pkg::ptr_t               right_front_q, right_front_d;
  tqsb_pkg::ptr_t               right_rear_q, right_rear_d;
  tqsb_pkg::ptr_t               idx_q, idx_d;
  tqsb_pkg::cnt_t               cnt_q, cnt_d;

  logic           left_empty, right_empty, full;
  logic           side_right, is_pop, fin, res_fire;
  tqsb_pkg::ptr_t push_idx, rear, next_idx;

  assign left_empty  = (left_front_q < 0) || (left_front_q > left_rear_q);
  assign right_empty = (right_front_q >= tqsb_pkg::SLOTS) || (right_front_q < right_rear_q);
  assign full        = (right_rear_q - left_rear_q) < 2;

  assign side_right = (req_q == tqsb_pkg::REQ_PUSH_R) || (req_q == tqsb_pkg::REQ_POP_R) ||
                      (req_q == tqsb_pkg::REQ_LIST_R);
  assign is_pop     = (req_q == tqsb_pkg::REQ_POP_L) || (req_q == tqsb_pkg::REQ_POP_R);
  assign push_idx   = side_right ? (right_rear_q - tqsb_pkg::ptr_t'(1))
                                 : (left_rear_q + tqsb_pkg::ptr_t'(1));
  assign rear       = side_right ? right_rear_q : left_rear_q;
  assign next_idx   = side_right ? (idx_q - tqsb_pkg::ptr_t'(1))
                                 : (idx_q + tqsb_pkg::ptr_t'(1));
  assign fin        = is_pop || (idx_q == rear) ||
                      (cnt_q == tqsb_pkg::cnt_t'(tqsb_pkg::LIST_MAX - 1));
  assign res_fire   = res_valid_o && res_ready_i;

  assign in_ready_o  = (state_q == S_IDLE);
  assign ram_wdata_o = val_q;

  always_comb begin
    state_d       = state_q;
    left_front_d  = left_front_q;
    left_rear_d   = left_rear_q;
    right_front_d = right_front_q;
    right_rear_d  = right_rear_q;
    idx_d         = idx_q;
    cnt_d         = cnt_q;
    res_valid_o   = 1'b0;
    res_o.status  = tqsb_pkg::ST_OK;
    res_o.slot    = '0;
    res_o.data    = '0;
    res_o.last    = 1'b1;
    ram_we_o      = 1'b0;
    ram_waddr_o   = tqsb_pkg::addr_t'(push_idx);
    ram_re_o      = 1'b0;
    ram_raddr_o   = tqsb_pkg::addr_t'(idx_q);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (req_q)
          tqsb_pkg::REQ_PUSH_L, tqsb_pkg::REQ_PUSH_R: begin
            res_valid_o = 1'b1;
            if (full) begin
              res_o.status = tqsb_pkg::ST_OVF;
            end else begin
              res_o.slot = tqsb_pkg::slot_t'($unsigned(push_idx));
            end
            // Memory and pointers change only once the result is handed over.
            if (res_fire) begin
              state_d = S_IDLE;
              if (!full) begin
                ram_we_o = 1'b1;
                if (side_right) begin
                  right_rear_d = push_idx;
                  if (right_front_q >= tqsb_pkg::SLOTS) begin
                    right_front_d = push_idx;
                  end
                end else begin
                  left_rear_d = push_idx;
                  if (left_front_q < 0) begin
                    left_front_d = push_idx;
                  end
                end
              end
            end
          end
          tqsb_pkg::REQ_POP_L, tqsb_pkg::REQ_LIST_L,
          tqsb_pkg::REQ_POP_R, tqsb_pkg::REQ_LIST_R: begin
            if (side_right ? right_empty : left_empty) begin
              res_valid_o  = 1'b1;
              res_o.status = tqsb_pkg::ST_EMPTY;
              if (res_fire) begin
                state_d = S_IDLE;
              end
            end else begin
              idx_d       = side_right ? right_front_q : left_front_q;
              cnt_d       = '0;
              ram_re_o    = 1'b1;
              ram_raddr_o = tqsb_pkg::addr_t'(idx_d);
              state_d     = S_READ;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        // The read data register holds its value until the next read is issued.
        res_valid_o = 1'b1;
        res_o.slot  = tqsb_pkg::slot_t'($unsigned(idx_q));
        res_o.data  = ram_rdata_i;
        res_o.last  = fin;
        if (res_fire) begin
          if (is_pop) begin
            if (side_right) begin
              right_front_d = right_front_q - tqsb_pkg::ptr_t'(1);
            end else begin
              left_front_d = left_front_q + tqsb_pkg::ptr_t'(1);
            end
          end
          if (fin) begin
            state_d = S_IDLE;
          end else begin
            idx_d       = next_idx;
            cnt_d       = cnt_q + tqsb_pkg::cnt_t'(1);
            ram_re_o    = 1'b1;
            ram_raddr_o = tqsb_pkg::addr_t'(next_idx);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      left_front_q  <= tqsb_pkg::ptr_t'(-1);
      left_rear_q   <= tqsb_pkg::ptr_t'(-1);
      right_front_q <= tqsb_pkg::ptr_t'(tqsb_pkg::SLOTS);
      right_rear_q  <= tqsb_pkg::ptr_t'(tqsb_pkg::SLOTS);
      idx_q         <= '0;
      cnt_q         <= '0;
    end else begin
      state_q       <= state_d;
      left_front_q  <= left_front_d;
      left_rear_q   <= left_rear_d;
      right_front_q <= right_front_d;
      right_rear_q  <= right_rear_d;
      idx_q         <= idx_d;
      cnt_q         <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= req_type_i;
      val_q <= push_value_i;
    end
  end

  `TQSB_ASSERT(a_rears_apart, left_rear_q < right_rear_q, "queue rears crossed")
  `TQSB_ASSERT(a_read_in_range, (state_q != S_READ) || ((idx_q >= 0) && (idx_q < tqsb_pkg::SLOTS)), "read slot outside buffer")
  `TQSB_ASSERT_NEXT(a_write_moves_rear, ram_we_o, (left_rear_q != $past(left_rear_q)) || (right_rear_q != $past(right_rear_q)), "buffer write without rear update")
  `TQSB_ASSERT_NEXT(a_list_continues, (state_q == S_READ) && res_fire && !fin, state_q == S_READ, "listing ended early")

endmodule
